@@ hdl/cau_pkg.sv @@
// Shared types, codes and defaults for the complex arithmetic unit.
package cau_pkg;

	// Default sizes, handed to the top level parameters
	localparam int DEF_WORD_BITS = 32;
	localparam int DEF_FRAC_BITS = 16;
	localparam int DEF_MAX_EXP   = 64;

	// Fixed field widths
	localparam int CMD_BITS  = 3;
	localparam int EXP_BITS  = 8;
	localparam int STAT_BITS = 2;

	// Command codes
	localparam logic [CMD_BITS-1:0] CMD_ADD  = 3'd0;
	localparam logic [CMD_BITS-1:0] CMD_SUB  = 3'd1;
	localparam logic [CMD_BITS-1:0] CMD_MUL  = 3'd2;
	localparam logic [CMD_BITS-1:0] CMD_DIV  = 3'd3;
	localparam logic [CMD_BITS-1:0] CMD_CONJ = 3'd4;
	localparam logic [CMD_BITS-1:0] CMD_NEG  = 3'd5;
	localparam logic [CMD_BITS-1:0] CMD_POW  = 3'd6;

	// Status codes
	localparam logic [STAT_BITS-1:0] STAT_OK  = 2'd0;
	localparam logic [STAT_BITS-1:0] STAT_DZ  = 2'd1;
	localparam logic [STAT_BITS-1:0] STAT_OVF = 2'd2;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROD,
		ST_MFIN,
		ST_DRS,
		ST_DRW,
		ST_DIS,
		ST_DIW,
		ST_STEP
	} state_t;

	// Sequencer controls
	typedef struct packed {
		logic mul_issue;
		logic div_start;
		logic div_imag;
	} ctl_t;

endpackage

@@ hdl/cau_mul.sv @@
// Shared signed multiplier with a registered product.
module cau_mul #(
	parameter int WORD_BITS = cau_pkg::DEF_WORD_BITS
) (
	input  logic                          clk,
	input  logic signed [WORD_BITS-1:0]   x,
	input  logic signed [WORD_BITS-1:0]   y,
	output logic signed [2*WORD_BITS-1:0] p_s1
);
	import cau_pkg::*;

	// one product per cycle
	always_ff @(posedge clk) begin
		p_s1 <= x * y;
	end

endmodule

@@ hdl/cau_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module cau_div #(
	parameter int NUM_BITS = 80,
	parameter int DEN_BITS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] num,
	input  logic [DEN_BITS-1:0] den,
	output logic                done,
	output logic [NUM_BITS-1:0] quo
);
	import cau_pkg::*;

	localparam int CNT_BITS = $clog2(NUM_BITS + 1);

	logic                run_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [DEN_BITS-1:0] rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [NUM_BITS-1:0] quo_q;
	logic [DEN_BITS:0]   rem_sh;
	logic                ge;

	// trial subtract on shifted remainder
	assign rem_sh = {rem_q, quo_q[NUM_BITS-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_BITS'(NUM_BITS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (run_q) begin
			rem_q <= ge ? DEN_BITS'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_BITS-1:0];
			quo_q <= {quo_q[NUM_BITS-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

@@ hdl/complex_arith_unit.sv @@
// Top level of the complex arithmetic unit: sequencer and datapath.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  request   | start, busy          | command, a_real, a_imag, b_real, b_imag,
//            |                      | exponent
//  result    | done (one cycle)     | res_real, res_imag, status
//
// Add, subtract, conjugate, negate, unused codes, divide by zero and the
// power requests that need no step: done in the cycle after accept.
// Multiply: 4 products on the shared multiplier, then the product pipeline
// drains, and a rounding step (ST_MFIN) and a final step (ST_STEP) follow.
// Divide: 6 products, then two radix-2 divisions of 2*WORD_BITS+FRAC_BITS
// quotient bits, each begun by a start state (ST_DRS, ST_DIS) and followed by
// a wait for the divider (ST_DRW, ST_DIW), then a final step (ST_STEP).
// Power: one multiply or divide step per unit of |exponent|, clamped
// to MAX_EXP.
// busy is high for the whole of a multi-cycle request; reset returns to idle.
// The receiver cannot stall: done marks a result for exactly one cycle.
module complex_arith_unit #(
	parameter int WORD_BITS = cau_pkg::DEF_WORD_BITS,
	parameter int FRAC_BITS = cau_pkg::DEF_FRAC_BITS,
	parameter int MAX_EXP   = cau_pkg::DEF_MAX_EXP
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [cau_pkg::CMD_BITS-1:0]     command,
	input  logic signed [WORD_BITS-1:0]      a_real,
	input  logic signed [WORD_BITS-1:0]      a_imag,
	input  logic signed [WORD_BITS-1:0]      b_real,
	input  logic signed [WORD_BITS-1:0]      b_imag,
	input  logic signed [cau_pkg::EXP_BITS-1:0] exponent,
	output logic                             done,
	output logic signed [WORD_BITS-1:0]      res_real,
	output logic signed [WORD_BITS-1:0]      res_imag,
	output logic [cau_pkg::STAT_BITS-1:0]    status
);
	import cau_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int PW = 2 * W;
	localparam int SW = 2 * W + 1;
	localparam int NW = 2 * W + FRAC_BITS;

	// clamp to signed word from sign and magnitude; top bit is overflow
	function automatic logic [W:0] sat_sm(input logic neg, input logic [NW-1:0] mag);
		logic [NW-1:0] lim;
		logic [W-1:0]  m;
		logic          ovf;
		lim = (NW'(1) << (W - 1)) - NW'(!neg);
		ovf = mag > lim;
		m   = ovf ? lim[W-1:0] : mag[W-1:0];
		return {ovf, neg ? (~m + 1'b1) : m};
	endfunction

	// clamp a (W+1)-bit signed value
	function automatic logic [W:0] sat_n(input logic [W:0] s);
		logic [W:0] mag;
		mag = s[W] ? (~s + 1'b1) : s;
		return sat_sm(s[W], NW'(mag));
	endfunction

	state_t state_q, state_d;
	ctl_t   ctl;

	logic                  is_div_q;
	logic [EXP_BITS-1:0]   n_q;
	logic [2:0]            pk_q;
	logic [2:0]            ptag_s1;
	logic                  pvld_s1;
	logic                  ovf_q;
	logic                  done_q;
	logic [W-1:0]          xr_q, xi_q, yr_q, yi_q, tr_q, ti_q;
	logic signed [SW-1:0]  re_q, im_q;
	logic [PW-1:0]         den_q;
	logic [W-1:0]          res_r_q, res_i_q;
	logic [STAT_BITS-1:0]  stat_q;

	// request decode
	logic                  accept;
	logic                  a_zero, b_zero, eneg;
	logic [EXP_BITS-1:0]   nraw, nclamp;
	logic [W:0]            one_sat;
	logic [W:0]            add_r, add_i, sub_r, sub_i, cj_i, ng_r, ng_i;

	assign accept = start && (state_q == ST_IDLE);
	assign a_zero = (a_real == '0) && (a_imag == '0);
	assign b_zero = (b_real == '0) && (b_imag == '0);
	assign eneg   = exponent[EXP_BITS-1];
	assign nraw   = eneg ? (EXP_BITS'(0) - exponent) : exponent;
	assign nclamp = (nraw > EXP_BITS'(MAX_EXP)) ? EXP_BITS'(MAX_EXP) : nraw;
	assign one_sat = sat_sm(1'b0, NW'(1) << FRAC_BITS);

	// results for add, subtract, negate and conjugate
	assign add_r = sat_n({a_real[W-1], a_real} + {b_real[W-1], b_real});
	assign add_i = sat_n({a_imag[W-1], a_imag} + {b_imag[W-1], b_imag});
	assign sub_r = sat_n({a_real[W-1], a_real} - {b_real[W-1], b_real});
	assign sub_i = sat_n({a_imag[W-1], a_imag} - {b_imag[W-1], b_imag});
	assign ng_r  = sat_n((W+1)'(0) - {a_real[W-1], a_real});
	assign ng_i  = sat_n((W+1)'(0) - {a_imag[W-1], a_imag});
	assign cj_i  = ng_i;

	// shared multiplier operand select
	logic signed [W-1:0]  mx, my;
	logic signed [PW-1:0] p_s1;
	logic [2:0]           last_pk;

	assign last_pk = is_div_q ? 3'd5 : 3'd3;

	always_comb begin
		case (pk_q)
			3'd0:    begin mx = xr_q; my = yr_q; end
			3'd1:    begin mx = xi_q; my = yi_q; end
			3'd2:    begin mx = xr_q; my = yi_q; end
			3'd3:    begin mx = xi_q; my = yr_q; end
			3'd4:    begin mx = yr_q; my = yr_q; end
			default: begin mx = yi_q; my = yi_q; end
		endcase
	end

	cau_mul #(.WORD_BITS(W)) u_mul (
		.clk (clk),
		.x   (mx),
		.y   (my),
		.p_s1(p_s1)
	);

	// product rounding and divider operands
	logic            re_neg, im_neg;
	logic [SW-1:0]   re_abs, im_abs;
	logic [W:0]      mr_sat, mi_sat, dq_sat;
	logic [NW-1:0]   div_num, div_quo;
	logic            div_done;

	assign re_neg = re_q[SW-1];
	assign im_neg = im_q[SW-1];
	assign re_abs = re_neg ? (~re_q + 1'b1) : re_q;
	assign im_abs = im_neg ? (~im_q + 1'b1) : im_q;
	assign mr_sat = sat_sm(re_neg, NW'(re_abs[PW-1:0] >> FRAC_BITS));
	assign mi_sat = sat_sm(im_neg, NW'(im_abs[PW-1:0] >> FRAC_BITS));
	assign div_num = ctl.div_imag ? {im_abs[PW-1:0], FRAC_BITS'(0)}
	                              : {re_abs[PW-1:0], FRAC_BITS'(0)};
	assign dq_sat = sat_sm((state_q == ST_DIW) ? im_neg : re_neg, div_quo);

	cau_div #(.NUM_BITS(NW), .DEN_BITS(PW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (ctl.div_start),
		.num   (div_num),
		.den   (den_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (command)
						CMD_MUL: state_d = ST_PROD;
						CMD_DIV: state_d = b_zero ? ST_IDLE : ST_PROD;
						CMD_POW: state_d = ((eneg && a_zero) || nclamp == '0) ? ST_IDLE
						                                                     : ST_PROD;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_PROD: if (pk_q == last_pk + 3'd1) state_d = is_div_q ? ST_DRS : ST_MFIN;
			ST_MFIN: state_d = ST_STEP;
			ST_DRS:  state_d = ST_DRW;
			ST_DRW:  if (div_done) state_d = ST_DIS;
			ST_DIS:  state_d = ST_DIW;
			ST_DIW:  if (div_done) state_d = ST_STEP;
			ST_STEP: state_d = (n_q > EXP_BITS'(1)) ? ST_PROD : ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ctl = '0;
		case (state_q)
			ST_PROD: ctl.mul_issue = (pk_q <= last_pk);
			ST_DRS:  ctl.div_start = 1'b1;
			ST_DIS:  begin ctl.div_start = 1'b1; ctl.div_imag = 1'b1; end
			default: ctl = '0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pvld_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pvld_s1 <= ctl.mul_issue;
			done_q  <= 1'b0;
			if (accept) begin
				case (command)
					CMD_MUL: done_q <= 1'b0;
					CMD_DIV: done_q <= b_zero;
					CMD_POW: done_q <= (eneg && a_zero) || nclamp == '0;
					default: done_q <= 1'b1;
				endcase
			end else if (state_q == ST_STEP && n_q <= EXP_BITS'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		ptag_s1 <= pk_q;
		if (ctl.mul_issue || state_q == ST_PROD) pk_q <= pk_q + 3'd1;

		// accumulate the product issued last cycle
		if (pvld_s1) begin
			case (ptag_s1)
				3'd0: re_q <= re_q + {p_s1[PW-1], p_s1};
				3'd1: re_q <= is_div_q ? re_q + {p_s1[PW-1], p_s1} : re_q - {p_s1[PW-1], p_s1};
				3'd2: im_q <= is_div_q ? im_q - {p_s1[PW-1], p_s1} : im_q + {p_s1[PW-1], p_s1};
				3'd3: im_q <= im_q + {p_s1[PW-1], p_s1};
				default: den_q <= den_q + p_s1[PW-1:0];
			endcase
		end

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					pk_q  <= '0;
					re_q  <= '0;
					im_q  <= '0;
					den_q <= '0;
					ovf_q <= 1'b0;
					n_q   <= EXP_BITS'(1);
					stat_q <= STAT_OK;
					res_r_q <= '0;
					res_i_q <= '0;
					case (command)
						CMD_ADD: begin
							res_r_q <= add_r[W-1:0];
							res_i_q <= add_i[W-1:0];
							stat_q  <= (add_r[W] || add_i[W]) ? STAT_OVF : STAT_OK;
						end
						CMD_SUB: begin
							res_r_q <= sub_r[W-1:0];
							res_i_q <= sub_i[W-1:0];
							stat_q  <= (sub_r[W] || sub_i[W]) ? STAT_OVF : STAT_OK;
						end
						CMD_CONJ: begin
							res_r_q <= a_real;
							res_i_q <= cj_i[W-1:0];
							stat_q  <= cj_i[W] ? STAT_OVF : STAT_OK;
						end
						CMD_NEG: begin
							res_r_q <= ng_r[W-1:0];
							res_i_q <= ng_i[W-1:0];
							stat_q  <= (ng_r[W] || ng_i[W]) ? STAT_OVF : STAT_OK;
						end
						CMD_MUL, CMD_DIV: begin
							xr_q     <= a_real;
							xi_q     <= a_imag;
							yr_q     <= b_real;
							yi_q     <= b_imag;
							is_div_q <= (command == CMD_DIV);
							if (command == CMD_DIV && b_zero) stat_q <= STAT_DZ;
						end
						CMD_POW: begin
							xr_q     <= one_sat[W-1:0];
							xi_q     <= '0;
							yr_q     <= a_real;
							yi_q     <= a_imag;
							ovf_q    <= one_sat[W];
							is_div_q <= eneg;
							n_q      <= nclamp;
							if (eneg && a_zero) begin
								stat_q <= STAT_DZ;
							end else begin
								res_r_q <= one_sat[W-1:0];
								stat_q  <= one_sat[W] ? STAT_OVF : STAT_OK;
							end
						end
						default: stat_q <= STAT_OK;
					endcase
				end
			end
			ST_MFIN: begin
				tr_q  <= mr_sat[W-1:0];
				ti_q  <= mi_sat[W-1:0];
				ovf_q <= ovf_q | mr_sat[W] | mi_sat[W];
			end
			ST_DRW: begin
				if (div_done) begin
					tr_q  <= dq_sat[W-1:0];
					ovf_q <= ovf_q | dq_sat[W];
				end
			end
			ST_DIW: begin
				if (div_done) begin
					ti_q  <= dq_sat[W-1:0];
					ovf_q <= ovf_q | dq_sat[W];
				end
			end
			ST_STEP: begin
				xr_q <= tr_q;
				xi_q <= ti_q;
				if (n_q > EXP_BITS'(1)) begin
					n_q   <= n_q - 1'b1;
					pk_q  <= '0;
					re_q  <= '0;
					im_q  <= '0;
					den_q <= '0;
				end else begin
					res_r_q <= tr_q;
					res_i_q <= ti_q;
					stat_q  <= ovf_q ? STAT_OVF : STAT_OK;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign res_real = res_r_q;
	assign res_imag = res_i_q;
	assign status   = stat_q;

endmodule

@@ hdl/cau_checker.sv @@
// Port-level checks for the complex arithmetic unit, bound to the top level.
module cau_checker #(
	parameter int WORD_BITS = cau_pkg::DEF_WORD_BITS
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [WORD_BITS-1:0]          res_real,
	input logic [WORD_BITS-1:0]          res_imag,
	input logic [cau_pkg::STAT_BITS-1:0] status
);
	import cau_pkg::*;

	// a request either finishes at once or holds the unit busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("request neither finished nor started work");

	// a long request ends with its result
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// no result while still working
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// divide by zero gives zero
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STAT_DZ |-> res_real == '0 && res_imag == '0)
		else $error("divide by zero with nonzero result");

endmodule

bind complex_arith_unit cau_checker #(.WORD_BITS(WORD_BITS)) u_cau_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.res_real(res_real),
	.res_imag(res_imag),
	.status  (status)
);
